// ----- sv/longest_path_positive_cycle_check_assert.svh -----
// Assertion macros used by the solver back end (lpc_back).
`ifndef LONGEST_PATH_POSITIVE_CYCLE_CHECK_ASSERT_SVH
`define LONGEST_PATH_POSITIVE_CYCLE_CHECK_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lpc_pkg.sv -----
package lpc_pkg;

  localparam int LPC_MAX_NODES = 4096;
  localparam int LPC_MAX_EDGES = 8192;

  localparam int NODE_FW  = 13;
  localparam int WEIGHT_W = 32;
  localparam int SCORE_W  = 48;
  localparam int DIST_W   = 49;
  localparam int CFG_DW   = 32;
  localparam int CFG_AW   = 3;

  localparam logic [DIST_W-1:0]  DIST_TOP      = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic [DIST_W-1:0]  DIST_BOT      = {1'b1, {(DIST_W-1){1'b0}}};
  localparam logic [SCORE_W-1:0] NO_PATH_SCORE = {1'b1, {(SCORE_W-1){1'b0}}};

  // register index, taken from paddr[2]
  localparam logic CFG_IDX_NUM_NODES = 1'b0;

  typedef struct packed {
    logic [NODE_FW-1:0]         from;
    logic [NODE_FW-1:0]         to;
    logic signed [WEIGHT_W-1:0] weight;
  } edge_t;

endpackage

// ----- sv/lpc_if.sv -----
interface lpc_in_if;
  logic                               valid;
  logic                               ready;
  logic [lpc_pkg::NODE_FW-1:0]        edge_from;
  logic [lpc_pkg::NODE_FW-1:0]        edge_to;
  logic signed [lpc_pkg::WEIGHT_W-1:0] edge_weight;
  logic                               last_edge;

  modport source (output valid, edge_from, edge_to, edge_weight, last_edge, input ready);
  modport sink   (input valid, edge_from, edge_to, edge_weight, last_edge, output ready);
endinterface

interface lpc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [lpc_pkg::SCORE_W-1:0] max_score;
  logic                               unbounded;
  logic                               edge_overflow;

  modport source (output valid, max_score, unbounded, edge_overflow, input ready);
  modport sink   (input valid, max_score, unbounded, edge_overflow, output ready);
endinterface

// ----- sv/lpc_front.sv -----
module lpc_front #(
  parameter int MAX_EDGES = lpc_pkg::LPC_MAX_EDGES,
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int ECW = $clog2(MAX_EDGES + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  lpc_in_if.sink          in_ch,
  input  logic            busy,
  output logic            mem_we,
  output logic [EAW-1:0]  mem_addr,
  output lpc_pkg::edge_t  mem_data,
  output logic            push,
  output logic [ECW-1:0]  push_cnt,
  output logic            push_ovf
);
  import lpc_pkg::*;

  logic [ECW-1:0] cnt_r, cnt_nxt;
  logic           ovf_r, ovf_nxt;
  logic           acc, room;

  assign in_ch.ready = !busy;
  assign acc  = in_ch.valid && in_ch.ready;
  assign room = cnt_r < ECW'(MAX_EDGES);

  assign mem_we   = acc && room;
  assign mem_addr = EAW'(cnt_r);
  assign mem_data = '{from: in_ch.edge_from, to: in_ch.edge_to, weight: in_ch.edge_weight};

  assign push     = acc && in_ch.last_edge;
  assign push_cnt = room ? cnt_r + ECW'(1) : cnt_r;
  assign push_ovf = ovf_r || !room;

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (push) begin
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (mem_we) begin
      cnt_nxt = cnt_r + ECW'(1);
    end else if (acc) begin
      ovf_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

// ----- sv/lpc_job_q.sv -----
module lpc_job_q #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         nonempty,
  output logic [W-1:0] head
);
  logic [W-1:0] slot_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign nonempty = cnt_r != 2'd0;
  assign head     = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop && nonempty) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop && nonempty);
    end
  end

endmodule

// ----- sv/lpc_back.sv -----
`include "longest_path_positive_cycle_check_assert.svh"

module lpc_back #(
  parameter int MAX_NODES = lpc_pkg::LPC_MAX_NODES,
  parameter int MAX_EDGES = lpc_pkg::LPC_MAX_EDGES,
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int ECW = $clog2(MAX_EDGES + 1),
  localparam int NAW = $clog2(MAX_NODES),
  localparam int NW  = $clog2(MAX_NODES + 1),
  localparam int PW  = NW + 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         mem_we,
  input  logic [EAW-1:0]               mem_addr,
  input  lpc_pkg::edge_t               mem_data,
  input  logic                         job_valid,
  input  logic [ECW-1:0]               job_cnt,
  input  logic                         job_ovf,
  output logic                         job_pop,
  input  logic [lpc_pkg::NODE_FW-1:0]  num_nodes,
  output logic                         idle,
  lpc_out_if.source                    out_ch
);
  import lpc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_EDGE = 3'd2;
  localparam logic [2:0] S_NODE = 3'd3;
  localparam logic [2:0] S_EXEC = 3'd4;
  localparam logic [2:0] S_FRD  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  localparam logic [1:0] PH_RELAX = 2'd0;
  localparam logic [1:0] PH_REACH = 2'd1;
  localparam logic [1:0] PH_CHECK = 2'd2;

  // memories: edges, node {reached, distance}, reaches-destination bit
  edge_t             edge_mem [MAX_EDGES];
  logic [DIST_W:0]   node_mem [MAX_NODES];
  logic              rd_mem   [MAX_NODES];

  edge_t             edge_q;
  logic [DIST_W:0]   nf_q, nt_q;
  logic              rf_q, rt_q;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [EAW-1:0]    k_r, k_nxt;
  logic [NAW-1:0]    v_r, v_nxt;
  logic [PW-1:0]     pass_r, pass_nxt;
  logic              chg_r, chg_nxt;
  logic              unb_r, unb_nxt;
  logic [ECW-1:0]    cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [NW-1:0]     nn_r, nn_nxt, nn_cl;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [SCORE_W-1:0] score_r;
  logic                      unb_out_r, ovf_out_r;
  logic                      load_out;

  logic [NAW-1:0]    ia, ib;
  logic              nwe, rwe;
  logic [NAW-1:0]    nwa, rwa;
  logic [DIST_W:0]   nwd;
  logic              rwd;

  logic              e_valid, last_edge_k, chg_any;
  logic              relax_upd, reach_upd, cyc_hit;
  logic [DIST_W-1:0] df, dt, s_sat;
  logic [DIST_W:0]   sum;

  // clamp the node count into 1..MAX_NODES
  always_comb begin
    if (num_nodes == '0) nn_cl = NW'(1);
    else if (32'(num_nodes) > MAX_NODES) nn_cl = NW'(MAX_NODES);
    else nn_cl = NW'(num_nodes);
  end

  always_ff @(posedge clk) begin
    if (mem_we) edge_mem[mem_addr] <= mem_data;
    edge_q <= edge_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (nwe) node_mem[nwa] <= nwd;
    nf_q <= node_mem[ia];
    nt_q <= node_mem[ib];
  end

  always_ff @(posedge clk) begin
    if (rwe) rd_mem[rwa] <= rwd;
    rf_q <= rd_mem[ia];
    rt_q <= rd_mem[ib];
  end

  assign ia = (state_r == S_FRD || state_r == S_FIN) ? NAW'(nn_r - NW'(1))
                                                     : NAW'(edge_q.from - NODE_FW'(1));
  assign ib = NAW'(edge_q.to - NODE_FW'(1));

  assign e_valid = (edge_q.from != '0) && (32'(edge_q.from) <= 32'(nn_r)) &&
                   (edge_q.to != '0) && (32'(edge_q.to) <= 32'(nn_r));

  assign df  = nf_q[DIST_W-1:0];
  assign dt  = nt_q[DIST_W-1:0];
  assign sum = {df[DIST_W-1], df} +
               {{(DIST_W + 1 - WEIGHT_W){edge_q.weight[WEIGHT_W-1]}}, edge_q.weight};
  // saturate to the distance range
  assign s_sat = (sum[DIST_W] == sum[DIST_W-1]) ? sum[DIST_W-1:0]
               : (sum[DIST_W] ? DIST_BOT : DIST_TOP);

  assign relax_upd = e_valid && nf_q[DIST_W] &&
                     (!nt_q[DIST_W] || $signed(s_sat) > $signed(dt));
  assign reach_upd = e_valid && rt_q && !rf_q;
  assign cyc_hit   = e_valid && nf_q[DIST_W] && rt_q &&
                     (df == DIST_TOP || !nt_q[DIST_W] || $signed(s_sat) > $signed(dt));

  assign last_edge_k = ECW'(k_r) + ECW'(1) == cnt_r;
  assign chg_any = chg_r || (phase_r == PH_RELAX && relax_upd) ||
                   (phase_r == PH_REACH && reach_upd);

  assign idle    = state_r == S_IDLE;
  assign job_pop = idle && job_valid;

  assign nwe = (state_r == S_CLR) || (state_r == S_EXEC && phase_r == PH_RELAX && relax_upd);
  assign nwa = (state_r == S_CLR) ? v_r : ib;
  assign nwd = (state_r == S_CLR) ? {(v_r == '0), {DIST_W{1'b0}}} : {1'b1, s_sat};
  assign rwe = (state_r == S_CLR) || (state_r == S_EXEC && phase_r == PH_REACH && reach_upd);
  assign rwa = (state_r == S_CLR) ? v_r : ia;
  assign rwd = (state_r == S_CLR) ? (NW'(v_r) == nn_r - NW'(1)) : 1'b1;

  assign load_out = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    k_nxt     = k_r;
    v_nxt     = v_r;
    pass_nxt  = pass_r;
    chg_nxt   = chg_r;
    unb_nxt   = unb_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    nn_nxt    = nn_r;
    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          nn_nxt    = nn_cl;
          cnt_nxt   = job_cnt;
          ovf_nxt   = job_ovf;
          v_nxt     = '0;
          k_nxt     = '0;
          pass_nxt  = '0;
          chg_nxt   = 1'b0;
          unb_nxt   = 1'b0;
          phase_nxt = PH_RELAX;
          state_nxt = S_CLR;
        end
      end
      S_CLR: begin
        v_nxt = v_r + NAW'(1);
        if (NW'(v_r) == nn_r - NW'(1)) begin
          if (cnt_r == '0) state_nxt = S_FRD;
          else begin
            state_nxt = S_EDGE;
            if (nn_r == NW'(1)) phase_nxt = PH_REACH;
          end
        end
      end
      S_EDGE: state_nxt = S_NODE;
      S_NODE: state_nxt = S_EXEC;
      S_EXEC: begin
        state_nxt = S_EDGE;
        chg_nxt   = chg_any;
        k_nxt     = k_r + EAW'(1);
        if (phase_r == PH_CHECK && cyc_hit) begin
          unb_nxt   = 1'b1;
          state_nxt = S_FRD;
        end else if (last_edge_k) begin
          // end of a pass over the edges
          k_nxt    = '0;
          chg_nxt  = 1'b0;
          pass_nxt = pass_r + PW'(1);
          priority case (phase_r)
            PH_RELAX: begin
              if (!chg_any || pass_r + PW'(1) == PW'(nn_r) - PW'(1)) begin
                phase_nxt = PH_REACH;
                pass_nxt  = '0;
              end
            end
            PH_REACH: begin
              if (!chg_any || pass_r + PW'(1) == PW'(nn_r) + PW'(1)) begin
                phase_nxt = PH_CHECK;
                pass_nxt  = '0;
              end
            end
            default: state_nxt = S_FRD;
          endcase
        end
      end
      S_FRD: state_nxt = S_FIN;
      S_FIN: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      unb_out_r <= unb_r;
      ovf_out_r <= ovf_r;
      if (unb_r) score_r <= '0;
      else if (!nf_q[DIST_W]) score_r <= NO_PATH_SCORE;
      else score_r <= nf_q[SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_RELAX;
      k_r         <= '0;
      v_r         <= '0;
      pass_r      <= '0;
      chg_r       <= 1'b0;
      unb_r       <= 1'b0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      nn_r        <= NW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      k_r         <= k_nxt;
      v_r         <= v_nxt;
      pass_r      <= pass_nxt;
      chg_r       <= chg_nxt;
      unb_r       <= unb_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      nn_r        <= nn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.max_score     = score_r;
  assign out_ch.unbounded     = unb_out_r;
  assign out_ch.edge_overflow = ovf_out_r;

  `LPC_ASSERT_NEXT(a_start_clear, state_r == S_IDLE && job_valid, state_r == S_CLR, "job not started")
  `LPC_ASSERT_NOW(a_edge_in_range, state_r == S_EDGE, ECW'(k_r) < cnt_r, "edge index past count")
  `LPC_ASSERT_NOW(a_node_write, nwe, state_r == S_CLR || state_r == S_EXEC, "stray node write")
  `LPC_ASSERT_NOW(a_result_order, load_out, !out_valid_r || out_ch.ready, "result overwritten")

endmodule

// ----- sv/longest_path_positive_cycle_check.sv -----
// Channel  | Dir | Transfer when              | Carries
// in_ch    | in  | valid && ready             | edge_from, edge_to, edge_weight, last_edge
// out_ch   | out | valid && ready             | max_score, unbounded, edge_overflow
// cfg_*    | in  | psel && penable && pwrite  | num_nodes at byte address 0
//
// Edges are taken one per cycle while no graph is being solved.
// Solving a graph of N nodes and E edges: node clearing, then for each edge in each
// pass an edge read, a node read and an update (on a shared memory port pair),
// at most N-1 relaxation, N+1 reachability and one check pass, then a final node read and the result load.
// rst_n is synchronous; the result register lets the next graph load while
// a result waits on out_ch.ready.
module longest_path_positive_cycle_check #(
  parameter int MAX_NODES = lpc_pkg::LPC_MAX_NODES,
  parameter int MAX_EDGES = lpc_pkg::LPC_MAX_EDGES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lpc_in_if.sink                      in_ch,
  lpc_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lpc_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [lpc_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [lpc_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import lpc_pkg::*;

  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);

  logic [NODE_FW-1:0] num_nodes_r;
  logic               cfg_wr;

  logic               mem_we;
  logic [EAW-1:0]     mem_addr;
  edge_t              mem_data;
  logic               push, job_valid, job_pop, back_idle;
  logic [ECW-1:0]     push_cnt;
  logic               push_ovf;
  logic [ECW:0]       job_head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_NUM_NODES)
                    ? {{(CFG_DW - NODE_FW){1'b0}}, num_nodes_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_nodes_r <= NODE_FW'(1);
    end else if (cfg_wr && cfg_paddr[2] == CFG_IDX_NUM_NODES) begin
      num_nodes_r <= cfg_pwdata[NODE_FW-1:0];
    end
  end

  lpc_front #(.MAX_EDGES(MAX_EDGES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .busy     (job_valid || !back_idle),
    .mem_we   (mem_we),
    .mem_addr (mem_addr),
    .mem_data (mem_data),
    .push     (push),
    .push_cnt (push_cnt),
    .push_ovf (push_ovf)
  );

  lpc_job_q #(.W(ECW + 1)) u_job_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_ovf, push_cnt}),
    .pop       (job_pop),
    .nonempty  (job_valid),
    .head      (job_head)
  );

  lpc_back #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_data  (mem_data),
    .job_valid (job_valid),
    .job_cnt   (job_head[ECW-1:0]),
    .job_ovf   (job_head[ECW]),
    .job_pop   (job_pop),
    .num_nodes (num_nodes_r),
    .idle      (back_idle),
    .out_ch    (out_ch)
  );

endmodule
